@@ sv/gbrf_pkg.sv @@
// Shared types and constants for the GPIO bank register file.
// Holds opcode and register codes and the decoded command struct.
// No dependencies.
`default_nettype none

package gbrf_pkg;

   // Group index: bank (3 bits) and group within bank (2 bits).
   localparam int IDX_W = 5;
   localparam int BANK_W = 3;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_PIN   = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_CFG        = 3'd0,
      REG_OUT_EN     = 3'd1,
      REG_OUT        = 3'd2,
      REG_INPUT      = 3'd3,
      REG_IRQ_STATUS = 3'd4,
      REG_IRQ_ENABLE = 3'd5,
      REG_IRQ_LEVEL  = 3'd6,
      REG_CLEAR      = 3'd7
   } regno_type;

   // Decoded command: one read or one masked byte write against the file.
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic             bad;
      regno_type        regno;
      logic [IDX_W-1:0] idx;
      logic [7:0]       value;
      logic [7:0]       mask;
   } cmd_type;

endpackage

`default_nettype wire

@@ sv/gbrf_decode.sv @@
// Offset and pin decode for the GPIO bank register file.
// Turns one held request into a gbrf_pkg::cmd_type; depends on gbrf_pkg.
`default_nettype none

module gbrf_decode #(
   parameter int NUM_BANKS = 7
) (
   input  wire logic [1:0]       opcode,
   input  wire logic [11:0]      bus_offset,
   input  wire logic [15:0]      write_data,
   input  wire logic [7:0]       pin_number,
   input  wire logic             pin_level,
   output gbrf_pkg::cmd_type     cmd
);
   import gbrf_pkg::*;

   localparam logic [BANK_W-1:0] BANK_LIMIT = BANK_W'(NUM_BANKS);

   logic [BANK_W-1:0] bus_bank;
   logic [BANK_W-1:0] pin_bank;
   regno_type         bus_regno;
   logic              bus_bank_bad;
   logic              pin_bank_bad;
   logic              wr_ok;

   assign bus_bank     = bus_offset[9:7];
   assign pin_bank     = pin_number[7:5];
   assign bus_regno    = regno_type'(bus_offset[6:4]);
   assign bus_bank_bad = (bus_bank >= BANK_LIMIT);
   assign pin_bank_bad = (pin_bank >= BANK_LIMIT);

   always_comb begin
      wr_ok = bus_regno inside {REG_CFG, REG_OUT_EN, REG_OUT, REG_IRQ_STATUS, REG_IRQ_ENABLE};
      cmd       = '0;
      cmd.regno = bus_regno;
      cmd.idx   = {bus_bank, bus_offset[3:2]};
      case (opcode_type'(opcode))
         OP_READ: begin
            cmd.bad   = bus_bank_bad;
            cmd.rd_en = !bus_bank_bad;
         end
         OP_WRITE: begin
            cmd.bad   = bus_bank_bad;
            cmd.wr_en = !bus_bank_bad && wr_ok;
            cmd.value = write_data[7:0];
            // masked write keeps the pins whose mask bit is clear
            cmd.mask  = bus_offset[11] ? write_data[15:8] : 8'hff;
         end
         OP_PIN: begin
            cmd.bad   = pin_bank_bad;
            cmd.wr_en = !pin_bank_bad;
            cmd.regno = REG_INPUT;
            cmd.idx   = pin_number[7:3];
            cmd.value = {8{pin_level}};
            cmd.mask  = 8'h01 << pin_number[2:0];
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/gbrf_regfile.sv @@
// Byte storage for the GPIO bank register file: six arrays of group bytes.
// One read or one masked write per cycle; depends on gbrf_pkg.
`default_nettype none

module gbrf_regfile #(
   parameter int NUM_BANKS = 7
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_en,
   input  wire gbrf_pkg::cmd_type cmd,
   output logic [7:0]             rd_data
);
   import gbrf_pkg::*;

   localparam int DEPTH = NUM_BANKS * 4;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0] cfg_ff        [DEPTH];
   logic [7:0] out_en_ff     [DEPTH];
   logic [7:0] out_ff        [DEPTH];
   logic [7:0] input_ff      [DEPTH];
   logic [7:0] irq_status_ff [DEPTH];
   logic [7:0] irq_enable_ff [DEPTH];

   logic [AW-1:0] addr;
   logic [7:0]    cur_byte;
   logic [7:0]    merged_in;

   assign addr = cmd.idx[AW-1:0];

   // Current byte of the addressed register; level, clear and idle read 0.
   always_comb begin
      cur_byte = 8'h00;
      if (cmd.rd_en || cmd.wr_en) begin
         case (cmd.regno)
            REG_CFG:        cur_byte = cfg_ff[addr];
            REG_OUT_EN:     cur_byte = out_en_ff[addr];
            REG_OUT:        cur_byte = out_ff[addr];
            REG_INPUT:      cur_byte = input_ff[addr];
            REG_IRQ_STATUS: cur_byte = irq_status_ff[addr];
            REG_IRQ_ENABLE: cur_byte = irq_enable_ff[addr];
            default:        cur_byte = 8'h00;
         endcase
      end
   end

   assign rd_data   = cmd.rd_en ? cur_byte : 8'h00;
   assign merged_in = (cmd.value & cmd.mask) | (cur_byte & ~cmd.mask);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            cfg_ff[i]        <= 8'h00;
            out_en_ff[i]     <= 8'h00;
            out_ff[i]        <= 8'h00;
            input_ff[i]      <= 8'h00;
            irq_status_ff[i] <= 8'h00;
            irq_enable_ff[i] <= 8'h00;
         end
      end else if (cmd_en && cmd.wr_en) begin
         case (cmd.regno)
            REG_CFG:        cfg_ff[addr]        <= merged_in;
            REG_OUT_EN:     out_en_ff[addr]     <= merged_in;
            REG_OUT:        out_ff[addr]        <= merged_in;
            REG_INPUT:      input_ff[addr]      <= merged_in;
            REG_IRQ_STATUS: irq_status_ff[addr] <= merged_in;
            REG_IRQ_ENABLE: irq_enable_ff[addr] <= merged_in;
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ sv/gpio_bank_register_file_core.sv @@
// GPIO bank register file core: request register, decode, byte file, response register.
// A request loads the request register on transfer, then the response register, which drives rsp_valid.
// Throughput: one request per cycle while rsp_stall does not hold a full response register;
// the byte file does one read or one masked write per cycle.
// Reset (synchronous, active high) clears every register byte and both valid flags.
// Depends on gbrf_pkg, gbrf_decode and gbrf_regfile.
`default_nettype none

module gpio_bank_register_file_core #(
   parameter int NUM_BANKS = 7
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [11:0] req_bus_offset,
   input  wire logic [15:0] req_write_data,
   input  wire logic [7:0]  req_pin_number,
   input  wire logic        req_pin_level,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_bad_offset
);
   import gbrf_pkg::*;

   // Request register (stage 1)
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_opcode_ff;
   logic [11:0] s1_offset_ff;
   logic [15:0] s1_data_ff;
   logic [7:0]  s1_pin_ff;
   logic        s1_level_ff;

   // Response register (stage 2)
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_read_data_ff;
   logic        rsp_bad_offset_ff;

   logic        accept;
   logic        advance;
   cmd_type     cmd;
   logic [7:0]  rd_byte;

   // Advance the held request whenever the response register is empty or
   // being drained this cycle; the file update happens on that same edge.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   gbrf_decode #(
      .NUM_BANKS (NUM_BANKS)
   ) u_decode (
      .opcode     (s1_opcode_ff),
      .bus_offset (s1_offset_ff),
      .write_data (s1_data_ff),
      .pin_number (s1_pin_ff),
      .pin_level  (s1_level_ff),
      .cmd        (cmd)
   );

   // Commit writes only when the request moves into the response register,
   // so a stalled request never updates the file twice.
   gbrf_regfile #(
      .NUM_BANKS (NUM_BANKS)
   ) u_regfile (
      .clock   (clock),
      .reset   (reset),
      .cmd_en  (advance),
      .cmd     (cmd),
      .rd_data (rd_byte)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: capture on request transfer, hold the response while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_opcode_ff <= req_opcode;
         s1_offset_ff <= req_bus_offset;
         s1_data_ff   <= req_write_data;
         s1_pin_ff    <= req_pin_number;
         s1_level_ff  <= req_pin_level;
      end
      if (advance) begin
         rsp_read_data_ff  <= rd_byte;
         rsp_bad_offset_ff <= cmd.bad;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_bad_offset = rsp_bad_offset_ff;

   // A flagged offset never returns data.
   a_bad_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_offset_ff |-> rsp_read_data_ff == 8'h00)
      else $error("bad offset response carries data");

   // An empty response register never holds back the request side.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("request stalled with empty response register");

   // A decoded command is at most one of read, write, bad.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $onehot0({cmd.rd_en, cmd.wr_en, cmd.bad}))
      else $error("decoded command enables more than one action");

   // A request that moves on always lands in the response register.
   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request lost");

endmodule

`default_nettype wire
